[rtl/core/rbsi_pkg.sv]
// shared widths, sideband and interval types for the ray/box slab test
package rbsi_pkg;

    localparam int COORD_W  = 32;
    localparam int AXES     = 3;
    localparam int EPS_W    = 16;
    localparam int DEN_W    = 32;
    localparam int NUM_W    = 49;
    localparam int T_W      = NUM_W + 1;
    localparam int DIST_W   = 31;
    localparam int S_DATA_W = 12 * COORD_W;
    localparam int M_DATA_W = 32;

    localparam logic signed [T_W-1:0] DIST_MAX = T_W'(64'h7FFF_FFFF);

    typedef struct packed {
        logic par;
        logic out;
        logic neg0;
        logic neg1;
    } axis_sb_t;

    typedef struct packed {
        logic                  have;
        logic                  miss;
        logic signed [T_W-1:0] tmin;
        logic signed [T_W-1:0] tmax;
    } ivl_t;

endpackage

[rtl/core/ray_box_slab_intersect.sv]
// top level: ray versus axis-aligned box by the slab method, fully pipelined
// Usage:
//   s_ channel takes one item per ray/box pair in s_tdata; m_ channel returns
//   the hit flag and entry distance in m_tdata. An item is taken at an edge
//   where tvalid and tready are both high.
//   the user writes the epsilon threshold through cfg_wen/cfg_wdata only
//   while idle, which the block does not enforce; it resets to 1.
// Throughput: one item per cycle while the output buffer is not full.
// Pipeline: one setup stage, 49 divider stages, one ordering stage, two
//   interval stages, then the output buffer.
//   The depth is set by the 49-bit restoring dividers, one quotient bit each
//   stage, six of them working side by side (two crossing times per axis).
// Stall: the results land in a two-entry output buffer; while it is full
//   the whole pipeline holds and s_tready is low, nothing is lost or
//   repeated. s_tready depends only on the buffer fill, not on m_tready.
// Reset: aresetn (synchronous, active low) empties the pipeline and buffer
//   and sets the threshold back to 1.
module ray_box_slab_intersect (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wen,
    input  logic [rbsi_pkg::EPS_W-1:0]     cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // ray_pos_x/y/z, ray_dir_x/y/z, box_min_x/y/z, box_max_x/y/z, 32 bits each
    input  logic [rbsi_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // hit [0], distance [31:1]
    output logic [rbsi_pkg::M_DATA_W-1:0]  m_tdata
);
    import rbsi_pkg::*;

    function automatic ivl_t ivl_step(ivl_t cur, axis_sb_t sb,
                                      logic signed [T_W-1:0] t0,
                                      logic signed [T_W-1:0] t1);
        ivl_t nx;
        nx = cur;
        if (!cur.miss) begin
            if (sb.par) begin
                if (sb.out) nx.miss = 1'b1;
            end else if (cur.have) begin
                if (cur.tmin > t1 || t0 > cur.tmax) begin
                    nx.miss = 1'b1;
                end else begin
                    if (t0 > cur.tmin) nx.tmin = t0;
                    if (t1 < cur.tmax) nx.tmax = t1;
                end
            end else begin
                nx.have = 1'b1;
                nx.tmin = t0;
                nx.tmax = t1;
            end
        end
        return nx;
    endfunction

    logic             en;
    logic [EPS_W-1:0] eps_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_W'(1);
        end else if (cfg_wen) begin
            eps_reg <= cfg_wdata;
        end
    end

    // ---- setup stage: differences, magnitudes, parallel checks
    logic             a_valid_reg;
    logic [NUM_W-1:0] a_num_reg [0:2*AXES-1];
    logic [DEN_W-1:0] a_den_reg [0:AXES-1];
    axis_sb_t [AXES-1:0] a_sb_reg;

    logic [NUM_W-1:0] a_num_next [0:2*AXES-1];
    logic [DEN_W-1:0] a_den_next [0:AXES-1];
    axis_sb_t [AXES-1:0] a_sb_next;

    always_comb begin
        logic signed [COORD_W-1:0] pos, dir, lo, hi;
        logic signed [COORD_W:0]   d0, d1;
        logic [COORD_W:0]          m0, m1;
        logic [DEN_W-1:0]          mag;
        for (int a = 0; a < AXES; a++) begin
            pos = s_tdata[a*COORD_W +: COORD_W];
            dir = s_tdata[(3+a)*COORD_W +: COORD_W];
            lo  = s_tdata[(6+a)*COORD_W +: COORD_W];
            hi  = s_tdata[(9+a)*COORD_W +: COORD_W];
            d0  = {lo[COORD_W-1], lo} - {pos[COORD_W-1], pos};
            d1  = {hi[COORD_W-1], hi} - {pos[COORD_W-1], pos};
            m0  = d0[COORD_W] ? -d0 : d0;
            m1  = d1[COORD_W] ? -d1 : d1;
            mag = dir[COORD_W-1] ? -dir : dir;
            a_num_next[2*a]   = {m0, 16'd0};
            a_num_next[2*a+1] = {m1, 16'd0};
            a_den_next[a]     = mag;
            a_sb_next[a].par  = (dir == '0) || (mag < {{(DEN_W-EPS_W){1'b0}}, eps_reg});
            a_sb_next[a].out  = (pos < lo) || (pos > hi);
            a_sb_next[a].neg0 = d0[COORD_W] ^ dir[COORD_W-1];
            a_sb_next[a].neg1 = d1[COORD_W] ^ dir[COORD_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 2*AXES; i++) a_num_reg[i] <= a_num_next[i];
            for (int a = 0; a < AXES; a++) a_den_reg[a] <= a_den_next[a];
            a_sb_reg <= a_sb_next;
        end
    end

    // ---- dividers with the sideband line beside them
    logic [NUM_W-1:0] quo [0:2*AXES-1];

    for (genvar i = 0; i < 2*AXES; i++) begin : g_div
        rbsi_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (a_num_reg[i]),
            .den  (a_den_reg[i/2]),
            .quo  (quo[i])
        );
    end

    logic [NUM_W-1:0]    vline_reg;
    axis_sb_t [AXES-1:0] sb_line_reg [0:NUM_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vline_reg <= '0;
        end else if (en) begin
            vline_reg <= {vline_reg[NUM_W-2:0], a_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_line_reg[0] <= a_sb_reg;
            for (int k = 1; k < NUM_W; k++) sb_line_reg[k] <= sb_line_reg[k-1];
        end
    end

    // ---- sign and order the crossing times
    logic                  c_valid_reg;
    logic signed [T_W-1:0] c_t0_reg [0:AXES-1];
    logic signed [T_W-1:0] c_t1_reg [0:AXES-1];
    axis_sb_t [AXES-1:0]   c_sb_reg;

    logic signed [T_W-1:0] c_t0_next [0:AXES-1];
    logic signed [T_W-1:0] c_t1_next [0:AXES-1];

    always_comb begin
        logic signed [T_W-1:0] u0, u1;
        axis_sb_t              sb;
        for (int a = 0; a < AXES; a++) begin
            sb = sb_line_reg[NUM_W-1][a];
            u0 = sb.neg0 ? -$signed({1'b0, quo[2*a]})   : $signed({1'b0, quo[2*a]});
            u1 = sb.neg1 ? -$signed({1'b0, quo[2*a+1]}) : $signed({1'b0, quo[2*a+1]});
            if (u0 > u1) begin
                c_t0_next[a] = u1;
                c_t1_next[a] = u0;
            end else begin
                c_t0_next[a] = u0;
                c_t1_next[a] = u1;
            end
        end
    end

    // ---- interval over x and y, then z and the end rules
    logic                  d_valid_reg;
    ivl_t                  d_ivl_reg;
    logic signed [T_W-1:0] d_t0_reg, d_t1_reg;
    axis_sb_t              d_sb_reg;

    logic              e_valid_reg;
    logic              e_hit_reg;
    logic [DIST_W-1:0] e_dist_reg;

    ivl_t              d_ivl_next, e_ivl;
    logic              e_hit_next;
    logic [DIST_W-1:0] e_dist_next;

    always_comb begin
        d_ivl_next = ivl_step('0, c_sb_reg[0], c_t0_reg[0], c_t1_reg[0]);
        d_ivl_next = ivl_step(d_ivl_next, c_sb_reg[1], c_t0_reg[1], c_t1_reg[1]);
    end

    always_comb begin
        e_ivl       = ivl_step(d_ivl_reg, d_sb_reg, d_t0_reg, d_t1_reg);
        e_hit_next  = 1'b0;
        e_dist_next = '0;
        if (!e_ivl.miss && e_ivl.have) begin
            if (e_ivl.tmin < 0) begin
                e_hit_next = (e_ivl.tmax > 0);
            end else begin
                e_hit_next  = 1'b1;
                e_dist_next = (e_ivl.tmin > DIST_MAX) ? DIST_MAX[DIST_W-1:0]
                                                      : e_ivl.tmin[DIST_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= vline_reg[NUM_W-1];
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < AXES; a++) begin
                c_t0_reg[a] <= c_t0_next[a];
                c_t1_reg[a] <= c_t1_next[a];
            end
            c_sb_reg   <= sb_line_reg[NUM_W-1];
            d_ivl_reg  <= d_ivl_next;
            d_t0_reg   <= c_t0_reg[2];
            d_t1_reg   <= c_t1_reg[2];
            d_sb_reg   <= c_sb_reg[2];
            e_hit_reg  <= e_hit_next;
            e_dist_reg <= e_dist_next;
        end
    end

    // ---- two-entry output buffer
    logic [M_DATA_W-1:0] buf_reg [0:1];
    logic [1:0]          cnt_reg;
    logic                wr_ptr_reg, rd_ptr_reg;
    logic                push, pop;

    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;
    assign push     = en && e_valid_reg;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = buf_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)      cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push) cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) buf_reg[wr_ptr_reg] <= {e_dist_reg, e_hit_reg};
    end

endmodule

[rtl/core/rbsi_div.sv]
// pipelined unsigned restoring divider, one quotient bit per stage
module rbsi_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [rbsi_pkg::NUM_W-1:0]  num,
    input  logic [rbsi_pkg::DEN_W-1:0]  den,
    output logic [rbsi_pkg::NUM_W-1:0]  quo
);
    import rbsi_pkg::*;

    logic [DEN_W-1:0] rem_reg [1:NUM_W];
    logic [NUM_W-1:0] nq_reg  [1:NUM_W];
    logic [DEN_W-1:0] den_reg [1:NUM_W];

    logic [DEN_W-1:0] rem_next [0:NUM_W-1];
    logic [NUM_W-1:0] nq_next  [0:NUM_W-1];
    logic [DEN_W-1:0] den_next [0:NUM_W-1];

    always_comb begin
        logic [DEN_W-1:0] r_in;
        logic [NUM_W-1:0] q_in;
        logic [DEN_W-1:0] d_in;
        logic [DEN_W:0]   sh;
        logic [DEN_W:0]   dif;
        logic             ge;
        for (int k = 0; k < NUM_W; k++) begin
            if (k == 0) begin
                r_in = '0;
                q_in = num;
                d_in = den;
            end else begin
                r_in = rem_reg[k];
                q_in = nq_reg[k];
                d_in = den_reg[k];
            end
            sh  = {r_in, q_in[NUM_W-1]};
            dif = sh - {1'b0, d_in};
            ge  = (sh >= {1'b0, d_in});
            rem_next[k] = ge ? dif[DEN_W-1:0] : sh[DEN_W-1:0];
            nq_next[k]  = {q_in[NUM_W-2:0], ge};
            den_next[k] = d_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NUM_W; k++) begin
                rem_reg[k+1] <= rem_next[k];
                nq_reg[k+1]  <= nq_next[k];
                den_reg[k+1] <= den_next[k];
            end
        end
    end

    assign quo = nq_reg[NUM_W];

endmodule

[tb/ray_box_slab_intersect_test.sv]
// testbench for the ray/box slab intersection block: directed and random items
`timescale 1ns / 1ps

module ray_box_slab_intersect_test;
    import rbsi_pkg::*;

    typedef struct packed {
        logic [30:0] distance;
        logic        hit;
    } slab_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wen = 1'b0;
    logic [EPS_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    logic [15:0]           eps_model;
    slab_result_t          hits_pending[$];
    int                    mismatch_cnt = 0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    hold_off_cycles = 0;

    always #10 aclk = ~aclk;

    ray_box_slab_intersect u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic longint crossing_time(longint num, longint den);
        longint n, d, q;
        n = (num < 0 ? -num : num) <<< 16;
        d = den < 0 ? -den : den;
        q = n / d;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic slab_result_t slab_hit(logic [S_DATA_W-1:0] item);
        slab_result_t r;
        bit have, miss;
        longint tmin, tmax, t0, t1, sw, pos, dir, lo, hi, mag;
        have = 0; miss = 0; tmin = 0; tmax = 0;
        for (int a = 0; a < AXES; a++) begin
            if (!miss) begin
                pos = longint'($signed(item[a*32 +: 32]));
                dir = longint'($signed(item[(3+a)*32 +: 32]));
                lo = longint'($signed(item[(6+a)*32 +: 32]));
                hi = longint'($signed(item[(9+a)*32 +: 32]));
                mag = dir < 0 ? -dir : dir;
                if (dir == 0 || mag < longint'(eps_model)) begin
                    if (pos < lo || pos > hi) miss = 1;
                end else begin
                    t0 = crossing_time(lo - pos, dir);
                    t1 = crossing_time(hi - pos, dir);
                    if (t0 > t1) begin
                        sw = t0; t0 = t1; t1 = sw;
                    end
                    if (have) begin
                        if (tmin > t1 || t0 > tmax) miss = 1;
                        else begin
                            if (t0 > tmin) tmin = t0;
                            if (t1 < tmax) tmax = t1;
                        end
                    end else begin
                        tmin = t0; tmax = t1; have = 1;
                    end
                end
            end
        end
        r = '0;
        if (!miss && have) begin
            if (tmin < 0) r.hit = (tmax > 0);
            else begin
                r.hit = 1'b1;
                r.distance = (tmin > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : tmin[30:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatch_cnt++;
    endtask

    // result checker
    always @(posedge aclk) begin
        slab_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (hits_pending.size() == 0) report_mismatch("unexpected item", m_tdata, 32'd0);
            else begin
                want = hits_pending.pop_front();
                if (got.hit !== want.hit)
                    report_mismatch("hit", 32'(got.hit), 32'(want.hit));
                if (got.distance !== want.distance)
                    report_mismatch("distance", 32'(got.distance), 32'(want.distance));
            end
        end
    end

    // receiver side
    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // s_tvalid stays high after the accept; an idle next call or test end drops it
    task automatic send_ray(logic [S_DATA_W-1:0] item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= item;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        hits_pending.push_back(slab_hit(item));
        @(negedge aclk);
    endtask

    function automatic logic [S_DATA_W-1:0] pack_ray(logic [31:0] p[3], logic [31:0] d[3],
                                                    logic [31:0] lo[3], logic [31:0] hi[3]);
        logic [S_DATA_W-1:0] v;
        for (int a = 0; a < 3; a++) begin
            v[a*32 +: 32] = p[a];
            v[(3+a)*32 +: 32] = d[a];
            v[(6+a)*32 +: 32] = lo[a];
            v[(9+a)*32 +: 32] = hi[a];
        end
        return v;
    endfunction

    task automatic drain_and_set_eps(logic [15:0] eps);
        while (hits_pending.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= eps;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        eps_model = eps;
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(40 << 16)) - (20 << 16));
            default: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] p[3], d[3], lo[3], hi[3];
        // origin outside a unit box, ray along +x
        p = '{32'hFFFD_0000, 0, 0}; d = '{32'h0001_0000, 0, 0};
        lo = '{32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000};
        hi = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
        send_ray(pack_ray(p, d, lo, hi));
        // origin inside
        p = '{0, 0, 0}; d = '{32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000};
        send_ray(pack_ray(p, d, lo, hi));
        // box behind origin
        p = '{32'h0003_0000, 0, 0}; d = '{32'h0001_0000, 0, 0};
        send_ray(pack_ray(p, d, lo, hi));
        // all axes parallel, origin inside
        p = '{0, 0, 0}; d = '{0, 0, 0};
        send_ray(pack_ray(p, d, lo, hi));
        // parallel axis outside slab
        p = '{32'hFFFD_0000, 32'h0005_0000, 0}; d = '{32'h0001_0000, 0, 0};
        send_ray(pack_ray(p, d, lo, hi));
        // empty interval
        p = '{32'hFFFD_0000, 32'hFFFD_0000, 0}; d = '{32'h0001_0000, 32'h0000_1000, 0};
        send_ray(pack_ray(p, d, lo, hi));
        // saturation: tiny direction, far box
        p = '{32'h8000_0000, 0, 0}; d = '{32'h0000_0001, 0, 0};
        lo = '{32'h7FFF_0000, 32'hFFFF_0000, 32'hFFFF_0000};
        hi = '{32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000};
        send_ray(pack_ray(p, d, lo, hi));
        // inverted box, extreme directions
        p = '{32'h8000_0000, 32'h7FFF_FFFF, 0}; d = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        lo = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
        hi = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000};
        send_ray(pack_ray(p, d, lo, hi));
        // entry time rounding to zero
        p = '{32'hFFFF_FFFF, 0, 0}; d = '{32'h7FFF_0000, 0, 0};
        lo = '{0, 32'hFFFF_0000, 32'hFFFF_0000};
        hi = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
        send_ray(pack_ray(p, d, lo, hi));
        // touching: tmax exactly 0
        p = '{32'h0001_0000, 0, 0}; d = '{32'h0001_0000, 0, 0};
        lo = '{32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000};
        send_ray(pack_ray(p, d, lo, hi));
        for (int i = 0; i < 8; i++) begin
            for (int a = 0; a < 3; a++) begin
                p[a] = {32{i[0]}}; d[a] = {32{i[1]}} ^ 32'h8000_0000;
                lo[a] = {32{i[2]}}; hi[a] = ~lo[a];
            end
            send_ray(pack_ray(p, d, lo, hi));
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic test_random(int count);
        logic [31:0] p[3], d[3], lo[3], hi[3], c0, c1;
        int mode;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(9) == 0 ? 0 : ($urandom_range(1) ? 1 : 2);
            for (int a = 0; a < 3; a++) begin
                p[a] = rand_coord(mode);
                case ($urandom_range(7))
                    0: d[a] = 0;
                    1: d[a] = $urandom_range(3);
                    2: d[a] = -$urandom_range(70000);
                    3: d[a] = $urandom();
                    default: d[a] = rand_coord(2);
                endcase
                c0 = rand_coord(mode); c1 = rand_coord(mode);
                if ($urandom_range(9) != 0 && $signed(c0) > $signed(c1)) begin
                    lo[a] = c1; hi[a] = c0;
                end else begin
                    lo[a] = c0; hi[a] = c1;
                end
            end
            send_ray(pack_ray(p, d, lo, hi));
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic test_backpressure();
        hold_off_cycles <= 400;
        test_random(100);
    endtask

    task automatic set_phase(int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
    endtask

    initial begin
        eps_model = 16'd1;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        set_phase(0, 0);     test_random(250);
        test_backpressure();
        drain_and_set_eps(16'd0);
        set_phase(86, 0);    test_random(200);
        drain_and_set_eps(16'hFFFF);
        test_directed();
        set_phase(0, 86);    test_random(250);
        drain_and_set_eps(16'h0100);
        set_phase(37, 37);   test_random(250);
        drain_and_set_eps(16'd1);
        set_phase(0, 0);     test_random(250);
        while (hits_pending.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
